// File: design/lrb64_pkg.sv
// Shared types and constants for the letter-rotate base64 decoder.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package lrb64_pkg;

  // Configuration register indexes
  localparam logic CFG_ROTATE_AMOUNT = 1'b0;
  localparam logic CFG_PREFIX_ENABLE = 1'b1;

  localparam int unsigned ROT_W     = 5;
  localparam int unsigned ALPHA_LEN = 26;
  localparam logic [ROT_W-1:0] ROT_RESET = 5'd18;

  // Characters of interest
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Text put in front of a leading "//"
  localparam int unsigned LEAD_LEN = 6;
  localparam logic [8*LEAD_LEN-1:0] LEAD_TEXT = "https:";

  // Result slots of one command, in output order
  localparam int unsigned SLOT_SLASH = LEAD_LEN;
  localparam int unsigned SLOT_BYTE  = LEAD_LEN + 1;
  localparam int unsigned SLOT_BARE  = LEAD_LEN + 2;
  localparam int unsigned NUM_SLOTS  = LEAD_LEN + 3;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // Configuration seen by the front
  typedef struct packed {
    logic [ROT_W-1:0] rotate_amount;
    logic             prefix_enable;
  } cfg_t;

  // One command from front to back: the results caused by one input beat
  typedef struct packed {
    logic       lead;      // emit "https:" first
    logic       slash;     // emit a held '/'
    logic       has_byte;  // emit the decoded byte
    logic [7:0] data;
    logic       eos;       // last command of the string
  } cmd_t;

  // Character of a lead-text slot
  function automatic logic [7:0] lead_char(input int unsigned idx);
    lead_char = LEAD_TEXT[8*(LEAD_LEN-1-idx) +: 8];
  endfunction

endpackage

// File: design/lrb64_front.sv
// Front end: rotates letters, decodes base64 sextets into bytes and tracks
// the leading-slash state; emits at most one command per beat. Uses lrb64_pkg.
`timescale 1ns / 1ps

module lrb64_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_char,
  input  logic                in_eos,
  input  lrb64_pkg::cfg_t     cfg,
  output logic                cmd_push,
  output lrb64_pkg::cmd_t     cmd
);
  import lrb64_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_HELD = 3'b010,
    PH_PASS = 3'b100
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  store_r, store_nxt;
  logic [2:0]  count_r, count_nxt;
  logic        stopped_r, stopped_nxt;

  logic             is_up, is_lo, is_digit, is_eq;
  logic [ROT_W-1:0] amt, off, roff;
  logic [5:0]       sum;
  logic [7:0]       off_full, dig_full;
  logic [5:0]       sextet;
  logic             sextet_ok;
  logic             take;
  logic             have_byte;
  logic [7:0]       byte_val;

  // Classify the raw byte
  assign is_up     = (in_char >= CH_UP_A) && (in_char <= CH_UP_Z);
  assign is_lo     = (in_char >= CH_LO_A) && (in_char <= CH_LO_Z);
  assign is_digit  = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
  assign is_eq     = (in_char == CH_EQUAL);

  // Rotate letters within their case
  assign amt      = (cfg.rotate_amount >= ROT_W'(ALPHA_LEN))
                    ? cfg.rotate_amount - ROT_W'(ALPHA_LEN) : cfg.rotate_amount;
  assign off_full = in_char - (is_up ? CH_UP_A : CH_LO_A);
  assign off      = off_full[ROT_W-1:0];
  assign sum      = {1'b0, off} + {1'b0, amt};
  assign roff     = (sum >= 6'(ALPHA_LEN)) ? ROT_W'(sum - 6'(ALPHA_LEN)) : sum[ROT_W-1:0];
  assign dig_full = in_char - CH_ZERO;

  // Map the rotated byte to a sextet
  always_comb begin
    sextet    = '0;
    sextet_ok = 1'b1;
    if (is_up) begin
      sextet = {1'b0, roff};
    end else if (is_lo) begin
      sextet = {1'b0, roff} + 6'(ALPHA_LEN);
    end else if (is_digit) begin
      sextet = dig_full[5:0] + 6'd52;
    end else if (in_char == CH_PLUS) begin
      sextet = 6'd62;
    end else if (in_char == CH_SLASH) begin
      sextet = 6'd63;
    end else begin
      sextet_ok = 1'b0;
    end
  end

  assign take = accept && !stopped_r && !is_eq && sextet_ok;

  // Pack the sextet into the bit store; a byte falls out every 8 bits
  always_comb begin
    store_nxt = store_r;
    count_nxt = count_r;
    have_byte = 1'b0;
    byte_val  = '0;
    if (take) begin
      case (count_r)
        3'd2: begin
          have_byte = 1'b1;
          byte_val  = {store_r[1:0], sextet};
          store_nxt = '0;
          count_nxt = 3'd0;
        end
        3'd4: begin
          have_byte = 1'b1;
          byte_val  = {store_r[3:0], sextet[5:2]};
          store_nxt = {4'd0, sextet[1:0]};
          count_nxt = 3'd2;
        end
        3'd6: begin
          have_byte = 1'b1;
          byte_val  = {store_r[5:0], sextet[5:4]};
          store_nxt = {2'd0, sextet[3:0]};
          count_nxt = 3'd4;
        end
        default: begin
          store_nxt = sextet;
          count_nxt = 3'd6;
        end
      endcase
    end
  end

  // Hold a leading slash, build the command
  always_comb begin
    phase_nxt   = phase_r;
    stopped_nxt = stopped_r;
    cmd         = '0;
    cmd.data    = byte_val;
    if (accept && !stopped_r && is_eq) begin
      stopped_nxt = 1'b1;
    end
    if (have_byte) begin
      case (phase_r)
        PH_WAIT: begin
          if (cfg.prefix_enable && (byte_val == CH_SLASH)) begin
            phase_nxt = PH_HELD;
          end else begin
            phase_nxt    = PH_PASS;
            cmd.has_byte = 1'b1;
          end
        end
        PH_HELD: begin
          phase_nxt    = PH_PASS;
          cmd.slash    = 1'b1;
          cmd.has_byte = 1'b1;
          cmd.lead     = cfg.prefix_enable && (byte_val == CH_SLASH);
        end
        default: begin
          phase_nxt    = PH_PASS;
          cmd.has_byte = 1'b1;
        end
      endcase
    end
    if (accept && in_eos) begin
      cmd.eos = 1'b1;
      if (phase_nxt == PH_HELD) begin
        cmd.slash = 1'b1;
      end
    end
  end

  assign cmd_push = accept && (cmd.eos || cmd.has_byte || cmd.slash);

  // Advance stream state; end of string clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      store_r   <= '0;
      count_r   <= '0;
      stopped_r <= 1'b0;
    end else if (accept && in_eos) begin
      phase_r   <= PH_WAIT;
      store_r   <= '0;
      count_r   <= '0;
      stopped_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      store_r   <= store_nxt;
      count_r   <= count_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// File: design/lrb64_queue.sv
// Command queue between front and back so each side stalls on its own.
// Uses lrb64_pkg for the command type.
`timescale 1ns / 1ps

module lrb64_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lrb64_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output lrb64_pkg::cmd_t head_data
);
  import lrb64_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Wrap pointers, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/lrb64_back.sv
// Back end: expands each queued command into result beats held in an output
// register, one per cycle while it is empty or being popped. Uses lrb64_pkg.
`timescale 1ns / 1ps

module lrb64_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  lrb64_pkg::cmd_t head_data,
  output logic            head_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [7:0]      out_char,
  output logic            out_char_valid,
  output logic            out_end_mark
);
  import lrb64_pkg::*;

  slot_mask_t done_r, done_nxt;
  slot_mask_t mask, pend, pos_oh;
  logic       bare, last, adv;
  logic [7:0] ch;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r;
  logic       out_char_valid_r;
  logic       out_end_mark_r;

  // Slots this command fills
  assign bare = head_data.eos && !(head_data.lead || head_data.slash || head_data.has_byte);
  always_comb begin
    mask                = '0;
    mask[LEAD_LEN-1:0]  = {LEAD_LEN{head_data.lead}};
    mask[SLOT_SLASH]    = head_data.slash;
    mask[SLOT_BYTE]     = head_data.has_byte;
    mask[SLOT_BARE]     = bare;
  end

  // Pick the lowest pending slot
  assign pend   = head_valid ? (mask & ~done_r) : '0;
  assign pos_oh = pend & (~pend + 1'b1);
  assign last   = ((pend & ~pos_oh) == '0);
  assign adv    = head_valid && (!out_valid_r || out_pop);

  always_comb begin
    ch = '0;
    for (int unsigned i = 0; i < LEAD_LEN; i++) begin
      if (pos_oh[i]) begin
        ch = ch | lead_char(i);
      end
    end
    if (pos_oh[SLOT_SLASH]) begin
      ch = ch | CH_SLASH;
    end
    if (pos_oh[SLOT_BYTE]) begin
      ch = ch | head_data.data;
    end
  end

  // Step through slots; drop the command after its last beat
  always_comb begin
    done_nxt = done_r;
    head_pop = 1'b0;
    if (adv) begin
      if (last) begin
        done_nxt = '0;
        head_pop = 1'b1;
      end else begin
        done_nxt = done_r | pos_oh;
      end
    end
  end

  always_comb begin
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_char_r       <= ch;
      out_char_valid_r <= !pos_oh[SLOT_BARE];
      out_end_mark_r   <= head_data.eos && last;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_char       = out_char_r;
  assign out_char_valid = out_char_valid_r;
  assign out_end_mark   = out_end_mark_r;

`ifndef SYNTH
  // Progress through a command only exists while a command is queued
  a_done_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r != '0) |-> head_valid)
    else $error("slot progress without a queued command");

  // Emitted slots are always slots of the head command
  a_done_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> ((done_r & ~mask) == '0))
    else $error("slot progress outside command mask");

  // A bare result only closes a string
  a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_char_valid_r) |-> (out_end_mark_r && (out_char_r == '0)))
    else $error("bare result without end mark");

  // Every queued command has at least one result
  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (mask != '0))
    else $error("queued command with no results");
`endif

endmodule

// File: design/letter_rotate_base64_decoder_unit.sv
// Top level of the letter-rotate base64 decoder: configuration registers,
// front end, command queue and back end. Uses lrb64_pkg.
`timescale 1ns / 1ps

// Takes one link character per cycle (push/full) and returns decoded bytes
// (empty/pop). The front end classifies and decodes a character in the cycle it is
// taken and writes at most one command into a QUEUE_DEPTH-entry queue; the back
// end emits one result per cycle from that queue while results are popped. A
// character gives zero, one or two results, or eight when "https:" goes in front
// of a leading "//", so the input runs at one character per cycle and stalls
// (full high) only when the back end falls behind and the queue fills. The first
// result of a character passes the queue and the output register. Letters are
// rotated by rotate_amount (register 0, taken modulo 26); prefix_enable (register
// 1) turns the https: insertion on. Write the registers only while idle.

module letter_rotate_base64_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_char,
  input  logic       in_end_of_string,
  // result channel
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char,
  output logic       out_char_valid,
  output logic       out_end_mark,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data
);
  import lrb64_pkg::*;

  cfg_t cfg_r;
  logic accept;
  logic cmd_push;
  cmd_t cmd;
  logic head_valid, head_pop;
  cmd_t head_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotate_amount <= ROT_RESET;
      cfg_r.prefix_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROTATE_AMOUNT: cfg_r.rotate_amount <= cfg_data;
        CFG_PREFIX_ENABLE: cfg_r.prefix_enable <= cfg_data[0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  assign accept = in_push && !in_full;

  lrb64_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_char  (in_char),
    .in_eos   (in_end_of_string),
    .cfg      (cfg_r),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  lrb64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_data  (cmd),
    .full       (in_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  lrb64_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_data      (head_data),
    .head_pop       (head_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_char       (out_char),
    .out_char_valid (out_char_valid),
    .out_end_mark   (out_end_mark)
  );

endmodule

// File: verif/lrb64_decode_checker.sv
// Checker for the letter-rotate base64 decoder: predicts the decoded bytes of
// every accepted character beat and compares them with the result beats.
// Depends on lrb64_pkg for widths and character constants.
`timescale 1ns / 1ps

module lrb64_decode_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  logic                        in_full,
  input  logic [7:0]                  in_char,
  input  logic                        in_end_of_string,
  input  logic                        out_empty,
  input  logic                        out_pop,
  input  logic [7:0]                  out_char,
  input  logic                        out_char_valid,
  input  logic                        out_end_mark,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [lrb64_pkg::ROT_W-1:0] cfg_data,
  output int                          mismatch_count,
  output int                          bytes_owed
);
  import lrb64_pkg::*;

  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_HELD  = 3'b010,
    PH_PASS  = 3'b100
  } lead_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       last;
  } dec_byte_t;

  localparam logic [47:0] HTTPS_TEXT   = "https:";
  localparam int          MAX_PER_BEAT = 8;

  // Register copies
  logic [ROT_W-1:0] rot_amount;
  logic             prefix_on;

  // Stream state
  logic [9:0]  bit_store;
  logic [3:0]  bit_count;
  logic        stopped;
  lead_phase_t phase;

  dec_byte_t owed_q[$];
  int        beat_results;
  int        errors;

  function automatic logic [7:0] rotate_fwd(input logic [7:0] c);
    int unsigned amt;
    amt = rot_amount % ALPHA_LEN;
    if (c >= CH_LO_A && c <= CH_LO_Z) return 8'((c - CH_LO_A + amt) % ALPHA_LEN + CH_LO_A);
    if (c >= CH_UP_A && c <= CH_UP_Z) return 8'((c - CH_UP_A + amt) % ALPHA_LEN + CH_UP_A);
    return c;
  endfunction

  // Value of a base64 symbol, 64 for anything outside the alphabet
  function automatic logic [6:0] symbol_value(input logic [7:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) return 7'(c - CH_UP_A);
    if (c >= CH_LO_A && c <= CH_LO_Z) return 7'(c - CH_LO_A + 26);
    if (c >= CH_ZERO && c <= CH_NINE) return 7'(c - CH_ZERO + 52);
    if (c == CH_PLUS) return 7'd62;
    if (c == CH_SLASH) return 7'd63;
    return 7'd64;
  endfunction

  task automatic clear_stream();
    bit_store = '0;
    bit_count = '0;
    stopped   = 1'b0;
    phase     = PH_FIRST;
  endtask

  task automatic emit_byte(input logic [7:0] ch, input logic valid);
    dec_byte_t e;
    if (beat_results < MAX_PER_BEAT) begin
      e.ch    = ch;
      e.valid = valid;
      e.last  = 1'b0;
      owed_q.insert(owed_q.size(), e);
      beat_results++;
    end
  endtask

  // Hold a leading slash, then release it with or without the https: lead
  task automatic route_byte(input logic [7:0] b);
    case (phase)
      PH_FIRST: begin
        if (prefix_on && b == CH_SLASH) begin
          phase = PH_HELD;
        end else begin
          phase = PH_PASS;
          emit_byte(b, 1'b1);
        end
      end
      PH_HELD: begin
        phase = PH_PASS;
        if (prefix_on && b == CH_SLASH) begin
          for (int i = 0; i < 6; i++) emit_byte(HTTPS_TEXT[8*(5-i) +: 8], 1'b1);
        end
        emit_byte(CH_SLASH, 1'b1);
        emit_byte(b, 1'b1);
      end
      default: emit_byte(b, 1'b1);
    endcase
  endtask

  task automatic decode_beat(input logic [7:0] c, input logic eos);
    logic [7:0]  r;
    logic [6:0]  v;
    logic [3:0]  cnt;
    logic [11:0] acc;
    dec_byte_t   tail;
    beat_results = 0;
    if (!stopped) begin
      r = rotate_fwd(c);
      if (r == CH_EQUAL) begin
        stopped = 1'b1;
      end else begin
        v = symbol_value(r);
        if (v < 7'd64) begin
          cnt = {1'b0, bit_count[2:0]} + 4'd6;
          acc = {bit_store[5:0], v[5:0]};
          if (cnt >= 4'd8) begin
            cnt = cnt - 4'd8;
            route_byte(8'(acc >> (cnt)));
            acc = acc & ((12'd1 << cnt) - 12'd1);
          end
          bit_store = acc[9:0];
          bit_count = cnt;
        end
      end
    end
    // Close the string: flush a held slash, mark the last beat
    if (eos) begin
      if (phase == PH_HELD) emit_byte(CH_SLASH, 1'b1);
      if (beat_results == 0) emit_byte(8'h00, 1'b0);
      tail      = owed_q.pop_back();
      tail.last = 1'b1;
      owed_q.insert(owed_q.size(), tail);
      clear_stream();
    end
  endtask

  always @(posedge clk) begin
    dec_byte_t want;
    if (!rst_n) begin
      rot_amount = ROT_RESET;
      prefix_on  = 1'b1;
      clear_stream();
      owed_q.delete();
      errors = 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        if (cfg_index == CFG_ROTATE_AMOUNT) rot_amount = cfg_data;
        else prefix_on = cfg_data[0];
      end
      // Predict every accepted character beat
      if (in_push && !in_full) decode_beat(in_char, in_end_of_string);
      // Compare every accepted result beat with the oldest prediction
      if (out_pop && !out_empty) begin
        if (owed_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: char %h valid %b end %b", $time,
                   out_char, out_char_valid, out_end_mark);
        end else begin
          want = owed_q.pop_front();
          if (out_char !== want.ch) begin
            errors++;
            $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
          end
          if (out_char_valid !== want.valid) begin
            errors++;
            $display("%0t: out_char_valid expected %b actual %b", $time, want.valid,
                     out_char_valid);
          end
          if (out_end_mark !== want.last) begin
            errors++;
            $display("%0t: out_end_mark expected %b actual %b", $time, want.last,
                     out_end_mark);
          end
        end
      end
    end
    mismatch_count <= errors;
    bytes_owed     <= owed_q.size();
  end

endmodule

// File: verif/letter_rotate_base64_decoder_unit_tb.sv
// Testbench top for the letter-rotate base64 decoder: drives directed and random
// links through the queue ports and gives the verdict. Uses lrb64_pkg, the
// decoder top level and lrb64_decode_checker.
`timescale 1ns / 1ps

module letter_rotate_base64_decoder_unit_tb;
  import lrb64_pkg::*;

  localparam int ITEMS_PER_PHASE = 100;
  localparam int QUIET_LIMIT     = 1000;
  localparam int SETTLE_CYCLES   = 8;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_push;
  logic             in_full;
  logic [7:0]       in_char;
  logic             in_end_of_string;
  logic             out_empty;
  logic             out_pop;
  logic [7:0]       out_char;
  logic             out_char_valid;
  logic             out_end_mark;
  logic             cfg_we;
  logic             cfg_index;
  logic [ROT_W-1:0] cfg_data;

  int               mismatch_count;
  int               bytes_owed;
  int               send_idle_pct = 0;
  int               pop_stall_pct = 0;
  int               items_sent;
  int               quiet_cycles  = 0;
  logic [ROT_W-1:0] cur_rot       = ROT_RESET;

  always #5 clk = ~clk;

  letter_rotate_base64_decoder_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_char          (in_char),
    .in_end_of_string (in_end_of_string),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_char         (out_char),
    .out_char_valid   (out_char_valid),
    .out_end_mark     (out_end_mark),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  lrb64_decode_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_char          (in_char),
    .in_end_of_string (in_end_of_string),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_char         (out_char),
    .out_char_valid   (out_char_valid),
    .out_end_mark     (out_end_mark),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .bytes_owed       (bytes_owed)
  );

  // Stall the result side at random
  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Raw character that becomes c once the block rotates it
  function automatic logic [7:0] hide_letter(input logic [7:0] c);
    int unsigned amt;
    amt = cur_rot % ALPHA_LEN;
    if (c >= CH_LO_A && c <= CH_LO_Z)
      return 8'((c - CH_LO_A + ALPHA_LEN - amt) % ALPHA_LEN + CH_LO_A);
    if (c >= CH_UP_A && c <= CH_UP_Z)
      return 8'((c - CH_UP_A + ALPHA_LEN - amt) % ALPHA_LEN + CH_UP_A);
    return c;
  endfunction

  function automatic logic [7:0] symbol_char(input logic [5:0] v);
    if (v < 26) return 8'(CH_UP_A + v);
    if (v < 52) return 8'(CH_LO_A + v - 26);
    if (v < 62) return 8'(CH_ZERO + v - 52);
    if (v == 62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  // Byte outside the alphabet and not '=': the block skips it
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) ||
               (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_SLASH ||
               c == CH_EQUAL);
    return c;
  endfunction

  // Offer one character beat, idling first at random; push stays high after
  task automatic push_item(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push          <= 1'b1;
    in_char          <= c;
    in_end_of_string <= eos;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Send rotated-form text, closing the string on the last character if asked
  task automatic send_link(input string txt, input bit to_end);
    for (int i = 0; i < txt.len(); i++) begin
      push_item(hide_letter(txt[i]), to_end && (i == txt.len() - 1));
      items_sent++;
    end
  endtask

  // Hold input until every predicted byte is out, then let the block settle
  task automatic drain_and_settle(input int extra);
    in_push <= 1'b0;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [ROT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_ROTATE_AMOUNT) cur_rot = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly encoded links (often with a leading "//"), some raw bytes, some broken
  task automatic send_random_link();
    logic [7:0]  plain[$];
    logic [7:0]  link[$];
    int          kind;
    int          len;
    int unsigned acc;
    int unsigned nbits;
    kind = $urandom_range(99);
    if (kind < 70) begin
      len = $urandom_range(7);
      if ($urandom_range(2) == 0) begin
        plain.insert(plain.size(), CH_SLASH);
        if ($urandom_range(3) != 0) plain.insert(plain.size(), CH_SLASH);
      end
      while (plain.size() < len) plain.insert(plain.size(), 8'($urandom_range(255)));
      acc   = 0;
      nbits = 0;
      foreach (plain[i]) begin
        acc   = (acc << 8) | plain[i];
        nbits = nbits + 8;
        while (nbits >= 6) begin
          nbits = nbits - 6;
          link.insert(link.size(), symbol_char(6'(acc >> nbits)));
        end
        acc = acc & ((1 << nbits) - 1);
      end
      if (nbits > 0) link.insert(link.size(), symbol_char(6'(acc << (6 - nbits))));
      // Padding, sometimes with symbols after it that must be dropped
      if ($urandom_range(1) == 1) begin
        link.insert(link.size(), CH_EQUAL);
        repeat ($urandom_range(2))
          link.insert(link.size(), symbol_char(6'($urandom_range(63))));
      end
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 10)) link.insert(link.size(), 8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(9) == 0) link.insert(link.size(), CH_EQUAL);
        else link.insert(link.size(), symbol_char(6'($urandom_range(63))));
      end
    end
    if (link.size() == 0) link.insert(link.size(), noise_char());
    foreach (link[i]) begin
      if ($urandom_range(19) == 0) push_item(noise_char(), 1'b0);
      push_item(hide_letter(link[i]), i == link.size() - 1);
      items_sent++;
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct,
                           input logic [ROT_W-1:0] rot, input logic pfx);
    drain_and_settle(SETTLE_CYCLES);
    write_cfg(CFG_ROTATE_AMOUNT, rot);
    write_cfg(CFG_PREFIX_ENABLE, {4'b0, pfx});
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    items_sent    = 0;
    while (items_sent < ITEMS_PER_PHASE) send_random_link();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_push          = 1'b0;
    in_char          = 8'h00;
    in_end_of_string = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_ROTATE_AMOUNT;
    cfg_data         = '0;
    out_pop          = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: "//a" gets the https: lead
    send_link("Ly9h", 1'b1);
    // Lone slash at end of string
    drain_and_settle(SETTLE_CYCLES);
    write_cfg(CFG_ROTATE_AMOUNT, 5'd0);
    send_link("Lw", 1'b1);
    // Turn the prefix off while a slash is held
    send_link("Ly", 1'b0);
    drain_and_settle(SETTLE_CYCLES);
    write_cfg(CFG_PREFIX_ENABLE, 5'd0);
    send_link("8", 1'b1);
    send_link("Ly8", 1'b1);
    // Rotation past 25 wraps; '=' stops decoding for the rest of the string
    drain_and_settle(SETTLE_CYCLES);
    write_cfg(CFG_ROTATE_AMOUNT, 5'd31);
    write_cfg(CFG_PREFIX_ENABLE, 5'd1);
    send_link("QQ=Q", 1'b1);
    // Nothing to emit at end: bare end marker
    push_item(CH_EQUAL, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b1);
    drain_and_settle(SETTLE_CYCLES);
    write_cfg(CFG_ROTATE_AMOUNT, 5'd26);
    send_link("+/9z", 1'b1);

    run_phase(0, 0, 5'd25, 1'b1);
    run_phase(54, 0, 5'd0, 1'b0);
    run_phase(0, 54, 5'd31, 1'b1);
    run_phase(8, 8, 5'($urandom_range(31)), 1'($urandom_range(1)));

    drain_and_settle(3 * SETTLE_CYCLES);
    if (mismatch_count == 0 && bytes_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: letter_rotate_base64_decoder_unit.f
design/lrb64_pkg.sv
design/lrb64_front.sv
design/lrb64_queue.sv
design/lrb64_back.sv
design/letter_rotate_base64_decoder_unit.sv
verif/lrb64_decode_checker.sv
verif/letter_rotate_base64_decoder_unit_tb.sv
